// ===== design/iba_pkg.sv =====
package iba_pkg;

	// Default sizes
	localparam int NUM_BLOCKS_DEF      = 128;
	localparam int NUM_ENTRIES_DEF     = 16;
	localparam int MAX_FILE_BLOCKS_DEF = 8;

	// Block map is stored as rows of this many blocks
	localparam int MAP_ROW_W = 16;
	localparam int MAP_BIT_W = 4;

	localparam int NAME_W = 64;

	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SIZE   = 3'd1,
		ST_EXISTS     = 3'd2,
		ST_NO_BLOCKS  = 3'd3,
		ST_TABLE_FULL = 3'd4,
		ST_NOT_FOUND  = 3'd5
	} status_t;

endpackage

// ===== design/iba_ram.sv =====
module iba_ram
	import iba_pkg::*;
#(
	parameter int WIDTH = NAME_W,
	parameter int DEPTH = NUM_ENTRIES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/iba_block_map.sv =====
module iba_block_map
	import iba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int ROWS  = (NUM_BLOCKS + MAP_ROW_W - 1) / MAP_ROW_W,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ROW_W-1:0]     rd_row,
	output logic [MAP_ROW_W-1:0] rd_bits,
	input  logic                 wr_en,
	input  logic [ROW_W-1:0]     wr_row,
	input  logic [MAP_ROW_W-1:0] wr_bits
);

	logic [MAP_ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]      row_vld_q;
	logic [MAP_ROW_W-1:0] rd_data_q;
	logic [ROW_W-1:0]     rd_row_q;
	logic                 rd_vld_q;

	// Reset content of a row: block 0 reserved, blocks past the end taken
	function automatic logic [MAP_ROW_W-1:0] reset_bits(input logic [ROW_W-1:0] row);
		logic [ROW_W+MAP_BIT_W-1:0] g;
		logic [MAP_ROW_W-1:0]       b;
		b = '0;
		for (int i = 0; i < MAP_ROW_W; i++) begin
			g = {row, MAP_BIT_W'(i)};
			b[i] = (g == '0) || (32'(g) >= NUM_BLOCKS);
		end
		return b;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_bits;
		end
		rd_data_q <= mem[rd_row];
		rd_row_q  <= rd_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= row_vld_q[rd_row];
			if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
		end
	end

	assign rd_bits = rd_vld_q ? rd_data_q : reset_bits(rd_row_q);

endmodule

// ===== design/inode_block_allocator.sv =====
// Create: accept, name table scan, then a map row read per map row visited (a row
// found full moves on to the next) and one result per block handed out.
// Delete: accept, name table scan (ending early on a hit), then a pointer read, map
// read and map write per block freed, then the result. Errors: a bad size skips the scan.
// One request at a time; a stalled result holds the block. Reset: control, in-use and
// map row valid bits clear at once, free count set to NUM_BLOCKS - 1; no clearing pass.
module inode_block_allocator
	import iba_pkg::*;
#(
	parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
	parameter int NUM_ENTRIES     = NUM_ENTRIES_DEF,
	parameter int MAX_FILE_BLOCKS = MAX_FILE_BLOCKS_DEF,
	localparam int CNT_W = $clog2(MAX_FILE_BLOCKS + 1),
	localparam int ENT_W = $clog2(NUM_ENTRIES),
	localparam int BLK_W = $clog2(NUM_BLOCKS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              opcode,
	input  logic [NAME_W-1:0] file_name,
	input  logic [CNT_W-1:0]  block_count,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [2:0]        status,
	output logic [ENT_W-1:0]  entry_index,
	output logic [BLK_W-1:0]  block_index,
	output logic              last_result
);

	localparam int MAP_ROWS = (NUM_BLOCKS + MAP_ROW_W - 1) / MAP_ROW_W;
	localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int KW       = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
	localparam int FULL_W   = ROW_W + MAP_BIT_W;
	localparam int PTR_DEPTH = NUM_ENTRIES * (2 ** KW);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_A_RD  = 9'b000000100,
		S_A_WT  = 9'b000001000,
		S_A_BIT = 9'b000010000,
		S_D_PRD = 9'b000100000,
		S_D_MRD = 9'b001000000,
		S_D_MWR = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	// Request registers
	logic              op_q;
	logic [NAME_W-1:0] name_q;
	logic [CNT_W-1:0]  count_q;

	// Scan pipeline
	logic [ENT_W:0]    scan_idx_q;
	logic              cmp_vld_s1;
	logic [ENT_W-1:0]  cmp_idx_s1;
	logic              free_vld_q;
	logic [ENT_W-1:0]  free_idx_q;

	// Working registers
	logic [ENT_W-1:0]     ent_q;
	logic [CNT_W-1:0]     size_q;
	logic [CNT_W-1:0]     k_q;
	logic [ROW_W-1:0]     row_q;
	logic [MAP_ROW_W-1:0] bits_q;
	logic [ROW_W-1:0]     prow_q;
	logic [MAP_BIT_W-1:0] pbit_q;
	logic [BLK_W-1:0]     free_cnt_q;
	logic [NUM_ENTRIES-1:0] in_use_q;

	status_t           res_status_q;
	logic [ENT_W-1:0]  res_entry_q;

	// Output register
	logic              rsp_valid_q;
	status_t           status_q;
	logic [ENT_W-1:0]  entry_q;
	logic [BLK_W-1:0]  block_q;
	logic              last_q;

	// Memory ports
	logic [NAME_W+CNT_W-1:0] name_rdata;
	logic                    name_we;
	logic [BLK_W-1:0]        ptr_rd;
	logic [ENT_W+KW-1:0]     ptr_addr;
	logic [MAP_ROW_W-1:0]    map_rd_bits;
	logic [ROW_W-1:0]        map_rd_row;
	logic                    map_we;
	logic [ROW_W-1:0]        map_wr_row;
	logic [MAP_ROW_W-1:0]    map_wr_bits;

	// Datapath
	logic                 out_rdy;
	logic                 issue;
	logic [ENT_W-1:0]     scan_ent;
	logic                 hit;
	logic                 scan_last;
	logic                 short_blocks;
	logic [MAP_BIT_W-1:0] zbit;
	logic [MAP_ROW_W-1:0] nbits;
	logic [FULL_W-1:0]    blk_full;
	logic [FULL_W-1:0]    ptr_ext;
	logic                 row_full;
	logic                 alloc_fire;
	logic                 last_blk;
	logic                 del_last;

	always_comb begin
		out_rdy      = !rsp_valid_q || !rsp_stall;
		issue        = (state_q == S_SCAN) && (scan_idx_q < (ENT_W+1)'(NUM_ENTRIES));
		scan_ent     = scan_idx_q[ENT_W-1:0];
		// Match only entries in use; the all-zero name is an ordinary name
		hit          = cmp_vld_s1 && in_use_q[cmp_idx_s1]
		               && (name_rdata[NAME_W-1:0] == name_q);
		scan_last    = cmp_vld_s1 && (cmp_idx_s1 == ENT_W'(NUM_ENTRIES - 1));
		short_blocks = 32'(free_cnt_q) < 32'(count_q);

		// Lowest free block in the current row
		zbit = '0;
		for (int i = MAP_ROW_W - 1; i >= 0; i--) begin
			if (!bits_q[i]) begin
				zbit = MAP_BIT_W'(i);
			end
		end
		nbits    = bits_q | (MAP_ROW_W'(1) << zbit);
		blk_full = {row_q, zbit};
		ptr_ext  = FULL_W'(ptr_rd);
		row_full = &bits_q;

		alloc_fire = (state_q == S_A_BIT) && !row_full && out_rdy;
		last_blk   = (CNT_W'(k_q + CNT_W'(1)) == count_q);
		del_last   = (CNT_W'(k_q + CNT_W'(1)) == size_q);

		name_we = (state_q == S_SCAN) && !hit && scan_last && (op_q == OP_CREATE)
		          && !short_blocks && free_vld_q;
		ptr_addr = {ent_q, k_q[KW-1:0]};

		map_rd_row  = (state_q == S_D_MRD) ? ptr_ext[FULL_W-1:MAP_BIT_W] : row_q;
		map_we      = (alloc_fire && (last_blk || (&nbits))) || (state_q == S_D_MWR);
		map_wr_row  = (state_q == S_D_MWR) ? prow_q : row_q;
		map_wr_bits = (state_q == S_D_MWR) ? (map_rd_bits & ~(MAP_ROW_W'(1) << pbit_q))
		                                   : nbits;
	end

	iba_ram #(
		.WIDTH (NAME_W + CNT_W),
		.DEPTH (NUM_ENTRIES)
	) u_name_tbl (
		.clk     (clk),
		.wr_en   (name_we),
		.wr_addr (free_idx_q),
		.wr_data ({count_q, name_q}),
		.rd_addr (scan_ent),
		.rd_data (name_rdata)
	);

	iba_ram #(
		.WIDTH (BLK_W),
		.DEPTH (PTR_DEPTH)
	) u_ptr_tbl (
		.clk     (clk),
		.wr_en   (alloc_fire),
		.wr_addr (ptr_addr),
		.wr_data (blk_full[BLK_W-1:0]),
		.rd_addr (ptr_addr),
		.rd_data (ptr_rd)
	);

	iba_block_map #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_row  (map_rd_row),
		.rd_bits (map_rd_bits),
		.wr_en   (map_we),
		.wr_row  (map_wr_row),
		.wr_bits (map_wr_bits)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_CREATE;
			name_q       <= '0;
			count_q      <= '0;
			scan_idx_q   <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			free_vld_q   <= 1'b0;
			free_idx_q   <= '0;
			ent_q        <= '0;
			size_q       <= '0;
			k_q          <= '0;
			row_q        <= '0;
			bits_q       <= '0;
			prow_q       <= '0;
			pbit_q       <= '0;
			free_cnt_q   <= BLK_W'(NUM_BLOCKS - 1);
			in_use_q     <= '0;
			res_status_q <= ST_OK;
			res_entry_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q       <= opcode;
						name_q     <= file_name;
						count_q    <= block_count;
						scan_idx_q <= '0;
						cmp_vld_s1 <= 1'b0;
						free_vld_q <= 1'b0;
						k_q        <= '0;
						row_q      <= '0;
						res_entry_q <= '0;
						// Size check needs no table access
						if ((opcode == OP_CREATE) && ((block_count == '0)
						    || (block_count > CNT_W'(MAX_FILE_BLOCKS)))) begin
							res_status_q <= ST_BAD_SIZE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Issue one table read per cycle, compare in the cycle after
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= scan_ent;
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						if (!free_vld_q && !in_use_q[scan_ent]) begin
							free_vld_q <= 1'b1;
							free_idx_q <= scan_ent;
						end
					end
					if (hit) begin
						if (op_q == OP_CREATE) begin
							res_status_q <= ST_EXISTS;
							state_q      <= S_DONE;
						end else begin
							ent_q   <= cmp_idx_s1;
							size_q  <= name_rdata[NAME_W +: CNT_W];
							state_q <= S_D_PRD;
						end
					end else if (scan_last) begin
						if (op_q == OP_DELETE) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else if (short_blocks) begin
							res_status_q <= ST_NO_BLOCKS;
							state_q      <= S_DONE;
						end else if (!free_vld_q) begin
							res_status_q <= ST_TABLE_FULL;
							state_q      <= S_DONE;
						end else begin
							// Claim the entry; the name table write happens now too
							in_use_q[free_idx_q] <= 1'b1;
							ent_q   <= free_idx_q;
							state_q <= S_A_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_WT;
				end
				S_A_WT: begin
					bits_q  <= map_rd_bits;
					state_q <= S_A_BIT;
				end
				S_A_BIT: begin
					if (row_full) begin
						row_q   <= ROW_W'(row_q + 1'b1);
						state_q <= S_A_RD;
					end else if (out_rdy) begin
						k_q        <= CNT_W'(k_q + CNT_W'(1));
						free_cnt_q <= BLK_W'(free_cnt_q - 1'b1);
						if (last_blk) begin
							state_q <= S_IDLE;
						end else if (&nbits) begin
							row_q   <= ROW_W'(row_q + 1'b1);
							state_q <= S_A_RD;
						end else begin
							bits_q <= nbits;
						end
					end
				end
				S_D_PRD: begin
					state_q <= S_D_MRD;
				end
				S_D_MRD: begin
					prow_q  <= ptr_ext[FULL_W-1:MAP_BIT_W];
					pbit_q  <= ptr_ext[MAP_BIT_W-1:0];
					state_q <= S_D_MWR;
				end
				S_D_MWR: begin
					free_cnt_q <= BLK_W'(free_cnt_q + 1'b1);
					k_q        <= CNT_W'(k_q + CNT_W'(1));
					if (del_last) begin
						in_use_q[ent_q] <= 1'b0;
						res_status_q    <= ST_OK;
						res_entry_q     <= ent_q;
						state_q         <= S_DONE;
					end else begin
						state_q <= S_D_PRD;
					end
				end
				S_DONE: begin
					if (out_rdy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load a result when free or being taken, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			status_q    <= ST_OK;
			entry_q     <= '0;
			block_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (alloc_fire) begin
				rsp_valid_q <= 1'b1;
				status_q    <= ST_OK;
				entry_q     <= ent_q;
				block_q     <= blk_full[BLK_W-1:0];
				last_q      <= last_blk;
			end else if ((state_q == S_DONE) && out_rdy) begin
				rsp_valid_q <= 1'b1;
				status_q    <= res_status_q;
				entry_q     <= res_entry_q;
				block_q     <= '0;
				last_q      <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_index = entry_q;
	assign block_index = block_q;
	assign last_result = last_q;

`ifndef ASSERT_OFF
	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_cnt_q) < NUM_BLOCKS)
		else $error("free block count out of range");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q != ST_OK) |-> last_q && (entry_q == '0) && (block_q == '0))
		else $error("error result not single or not zeroed");

	a_alloc_block: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_fire |-> (blk_full != '0) && !bits_q[zbit]
		&& (32'(blk_full) < NUM_BLOCKS))
		else $error("allocated a reserved, taken or out-of-range block");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted without going busy");
`endif

endmodule

// ===== tb/sv/inode_block_allocator_tb.sv =====
`timescale 1ns / 100ps

module inode_block_allocator_tb;
	import iba_pkg::*;

	localparam int N_BLK   = NUM_BLOCKS_DEF;
	localparam int N_ENT   = NUM_ENTRIES_DEF;
	localparam int MAX_BLK = MAX_FILE_BLOCKS_DEF;
	localparam int CNT_W   = $clog2(MAX_BLK + 1);
	localparam int ENT_W   = $clog2(N_ENT);
	localparam int BLK_W   = $clog2(N_BLK);

	localparam int POOL_N      = 24;
	localparam int RANDOM_REQS = 270;
	// receiver hold-off window, in cycles after reset release
	localparam int HOLD_AT     = 3000;
	localparam int HOLD_LEN    = 240;

	typedef struct {
		logic              op;
		logic [NAME_W-1:0] name;
		logic [CNT_W-1:0]  count;
		int unsigned       gap;
	} fs_request_t;

	typedef struct {
		status_t           status;
		logic [ENT_W-1:0]  entry;
		logic [BLK_W-1:0]  block;
		logic              last;
	} alloc_result_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              req_valid   = 1'b0;
	logic              req_stall;
	logic              opcode      = OP_CREATE;
	logic [NAME_W-1:0] file_name   = '0;
	logic [CNT_W-1:0]  block_count = '0;
	logic              rsp_valid;
	logic              rsp_stall   = 1'b0;
	logic [2:0]        status;
	logic [ENT_W-1:0]  entry_index;
	logic [BLK_W-1:0]  block_index;
	logic              last_result;

	// shadow copy of the allocator state
	bit                block_taken [N_BLK];
	bit                entry_used  [N_ENT];
	logic [NAME_W-1:0] entry_name  [N_ENT];
	int                entry_size  [N_ENT];
	logic [BLK_W-1:0]  entry_blocks [N_ENT][MAX_BLK];

	fs_request_t       request_q[$];
	alloc_result_t     alloc_expect_q[$];
	logic [NAME_W-1:0] name_pool [POOL_N];

	fs_request_t       next_req;
	alloc_result_t     got_exp;
	int unsigned       req_gap;
	int unsigned       req_done;
	int unsigned       req_total;
	int unsigned       rsp_wait;
	int unsigned       rsp_wait_next;
	int unsigned       cycle_count;
	logic              hold_off;
	int unsigned       mismatch_count;

	inode_block_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.file_name   (file_name),
		.block_count (block_count),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.entry_index (entry_index),
		.block_index (block_index),
		.last_result (last_result)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(string what, logic [NAME_W-1:0] seen, logic [NAME_W-1:0] want);
		mismatch_count++;
		$display("%0t: %s got %0h expected %0h", $time, what, seen, want);
	endtask

	function automatic void push_result(status_t st, int entry, int block, bit last);
		alloc_result_t r;
		r.status = st;
		r.entry  = ENT_W'(entry);
		r.block  = BLK_W'(block);
		r.last   = last;
		alloc_expect_q.push_back(r);
	endfunction

	// Work out the results of one accepted request and advance the shadow state.
	function automatic void predict_allocation(logic op, logic [NAME_W-1:0] nm,
			logic [CNT_W-1:0] cnt);
		int hit;
		int slot;
		int free_n;
		int k;
		int b;
		int e;
		hit    = -1;
		slot   = -1;
		free_n = 0;
		k      = 0;
		// only entries in use take part in the name lookup
		for (e = 0; e < N_ENT; e++) begin
			if (hit < 0 && entry_used[e] && entry_name[e] == nm)
				hit = e;
			if (slot < 0 && !entry_used[e])
				slot = e;
		end
		for (b = 1; b < N_BLK; b++) begin
			if (!block_taken[b])
				free_n++;
		end
		if (op == OP_CREATE) begin
			// checks run in a fixed order; the first failure wins
			if (cnt == 0 || cnt > MAX_BLK) begin
				push_result(ST_BAD_SIZE, 0, 0, 1'b1);
			end else if (hit >= 0) begin
				push_result(ST_EXISTS, 0, 0, 1'b1);
			end else if (free_n < cnt) begin
				push_result(ST_NO_BLOCKS, 0, 0, 1'b1);
			end else if (slot < 0) begin
				push_result(ST_TABLE_FULL, 0, 0, 1'b1);
			end else begin
				entry_used[slot] = 1'b1;
				entry_name[slot] = nm;
				entry_size[slot] = cnt;
				// hand out the lowest free blocks, never block 0
				for (b = 1; b < N_BLK && k < cnt; b++) begin
					if (!block_taken[b]) begin
						block_taken[b] = 1'b1;
						entry_blocks[slot][k] = BLK_W'(b);
						push_result(ST_OK, slot, b, (k + 1 == cnt));
						k++;
					end
				end
			end
		end else begin
			if (hit < 0) begin
				push_result(ST_NOT_FOUND, 0, 0, 1'b1);
			end else begin
				for (k = 0; k < MAX_BLK; k++) begin
					if (k < entry_size[hit] && entry_blocks[hit][k] != 0)
						block_taken[entry_blocks[hit][k]] = 1'b0;
					entry_blocks[hit][k] = '0;
				end
				entry_used[hit] = 1'b0;
				entry_name[hit] = '0;
				entry_size[hit] = 0;
				push_result(ST_OK, hit, 0, 1'b1);
			end
		end
	endfunction

	task automatic add_request(logic op, logic [NAME_W-1:0] nm, logic [CNT_W-1:0] cnt,
			int unsigned gap);
		fs_request_t r;
		r.op    = op;
		r.name  = nm;
		r.count = cnt;
		r.gap   = gap;
		request_q.push_back(r);
	endtask

	// Sender: offer queued requests, hold each one while stalled, then idle for the
	// gap drawn with that request before offering the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid   <= 1'b0;
			opcode      <= OP_CREATE;
			file_name   <= '0;
			block_count <= '0;
			req_gap     <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_allocation(opcode, file_name, block_count);
				req_done++;
			end
			if (!req_valid || !req_stall) begin
				if (req_gap != 0) begin
					req_gap   <= req_gap - 1;
					req_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					next_req    = request_q.pop_front();
					req_valid   <= 1'b1;
					opcode      <= next_req.op;
					file_name   <= next_req.name;
					block_count <= next_req.count;
					req_gap     <= next_req.gap;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Cycle count and the long receiver hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
			hold_off    <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			hold_off    <= (cycle_count >= HOLD_AT && cycle_count < HOLD_AT + HOLD_LEN);
		end
	end

	// Receiver: check each accepted result against the oldest expectation, then
	// draw a stall for the next one; it runs free while cycle_count[9:8] is zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rsp_wait  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (alloc_expect_q.size() == 0) begin
					report_mismatch("unexpected result, status", status, 0);
				end else begin
					got_exp = alloc_expect_q.pop_front();
					if (status !== got_exp.status)
						report_mismatch("status", status, got_exp.status);
					if (entry_index !== got_exp.entry)
						report_mismatch("entry_index", entry_index, got_exp.entry);
					if (block_index !== got_exp.block)
						report_mismatch("block_index", block_index, got_exp.block);
					if (last_result !== got_exp.last)
						report_mismatch("last_result", last_result, got_exp.last);
				end
				rsp_wait_next = (cycle_count[9:8] == 2'b00) ? 0 : $urandom_range(0, 4);
			end else begin
				rsp_wait_next = (rsp_wait != 0) ? rsp_wait - 1 : 0;
			end
			rsp_wait  <= rsp_wait_next;
			rsp_stall <= hold_off || (rsp_wait_next != 0);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int i;
		int r;
		logic op;
		logic [NAME_W-1:0] nm;
		logic [CNT_W-1:0] cnt;

		req_done       = 0;
		mismatch_count = 0;
		for (i = 0; i < N_BLK; i++)
			block_taken[i] = (i == 0);
		for (i = 0; i < N_ENT; i++) begin
			entry_used[i] = 1'b0;
			entry_name[i] = '0;
			entry_size[i] = 0;
			for (r = 0; r < MAX_BLK; r++)
				entry_blocks[i][r] = '0;
		end
		// the all-zero name is an ordinary name and sits in the pool
		name_pool[0] = '0;
		for (i = 1; i < POOL_N; i++)
			name_pool[i] = {$urandom, $urandom};

		// Directed: size errors, name clash, miss on delete, delete ignores count.
		add_request(OP_CREATE, '0, 4'd0, 0);
		add_request(OP_CREATE, '0, 4'd15, $urandom_range(0, 4));
		add_request(OP_CREATE, '1, CNT_W'(MAX_BLK), 0);
		add_request(OP_CREATE, '1, 4'd1, $urandom_range(0, 4));
		add_request(OP_DELETE, '0, 4'd0, 0);
		add_request(OP_DELETE, '1, 4'd15, $urandom_range(0, 4));
		// Fill 15 entries with full-size files, leaving 7 blocks free.
		for (i = 0; i < N_ENT - 1; i++)
			add_request(OP_CREATE, name_pool[i], CNT_W'(MAX_BLK), (i % 3 == 0) ? 2 : 0);
		// Too few blocks, then take the last blocks into the last entry.
		add_request(OP_CREATE, name_pool[15], CNT_W'(MAX_BLK), 0);
		add_request(OP_CREATE, name_pool[15], 4'd7, 1);
		// Free one entry, reuse it, then hit a full table with blocks still free.
		add_request(OP_DELETE, name_pool[3], 4'd0, 0);
		add_request(OP_CREATE, name_pool[16], 4'd1, 0);
		add_request(OP_CREATE, name_pool[17], 4'd1, 3);

		// Random: mostly valid creates and deletes over a name pool a bit larger
		// than the table, with fresh names and bad sizes mixed in.
		for (i = 0; i < RANDOM_REQS; i++) begin
			op = ($urandom_range(0, 99) < 55) ? OP_CREATE : OP_DELETE;
			if ($urandom_range(0, 99) < 85)
				nm = name_pool[$urandom_range(0, POOL_N - 1)];
			else
				nm = {$urandom, $urandom};
			r = $urandom_range(0, 19);
			if (op == OP_DELETE)
				cnt = CNT_W'($urandom_range(0, 15));
			else if (r == 0)
				cnt = '0;
			else if (r == 1)
				cnt = CNT_W'($urandom_range(MAX_BLK + 1, 15));
			else if (r < 6)
				cnt = CNT_W'(MAX_BLK);
			else
				cnt = CNT_W'($urandom_range(1, MAX_BLK));
			// every third stretch of 30 requests goes back to back
			add_request(op, nm, cnt, ((i / 30) % 3 == 0) ? 0 : $urandom_range(0, 4));
		end
		req_total = request_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every request taken and every expected result seen.
		while (req_done < req_total || alloc_expect_q.size() != 0)
			@(posedge clk);
		// Allow a late stray result to show up.
		repeat (60) @(posedge clk);

		if (mismatch_count == 0 && alloc_expect_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
